[hw/rtl/lxrd_pkg.sv]
// Shared types, constants and a helper function for the record decryptor.
package lxrd_pkg;

    // Generator constants
    localparam logic [31:0] LCG_MUL = 32'h41C6_4E6D;
    localparam logic [31:0] LCG_ADD = 32'h0000_6073;

    // Record layout (word positions)
    localparam logic [7:0] SEED_LO    = 8'd0;
    localparam logic [7:0] SEED_HI    = 8'd1;
    localparam logic [7:0] SUM_WORD   = 8'd3;
    localparam logic [7:0] HDR_WORDS  = 8'd4;
    localparam logic [7:0] BLK_WORDS  = 8'd28;
    localparam logic [7:0] BOX_LAST   = 8'd115;
    localparam logic [7:0] BOX_END    = 8'd116;
    localparam logic [7:0] PARTY_LAST = 8'd129;
    localparam logic [7:0] PARTY_END  = 8'd130;

    // Shuffle selection
    localparam int         SHUF_TYPES = 24;
    localparam logic [4:0] SHUF_MOD   = 5'd24;
    localparam logic [4:0] OFF_LAST   = 5'd27;

    typedef logic [4:0] shuf_t;
    typedef logic [1:0] blk_t;
    typedef logic [4:0] off_t;

    // Word status codes
    typedef enum logic [1:0] {
        ST_PLAIN  = 2'd0,
        ST_PASS   = 2'd1,
        ST_FAIL   = 2'd2,
        ST_LENGTH = 2'd3
    } status_t;

    // Block order for each shuffle type: output block i is input block ORDER[t][i]
    localparam blk_t ORDER [SHUF_TYPES][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd1, 2'd3, 2'd2},
        '{2'd0, 2'd2, 2'd1, 2'd3}, '{2'd0, 2'd3, 2'd1, 2'd2},
        '{2'd0, 2'd2, 2'd3, 2'd1}, '{2'd0, 2'd3, 2'd2, 2'd1},
        '{2'd1, 2'd0, 2'd2, 2'd3}, '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd0, 2'd1, 2'd3}, '{2'd3, 2'd0, 2'd1, 2'd2},
        '{2'd2, 2'd0, 2'd3, 2'd1}, '{2'd3, 2'd0, 2'd2, 2'd1},
        '{2'd1, 2'd2, 2'd0, 2'd3}, '{2'd1, 2'd3, 2'd0, 2'd2},
        '{2'd2, 2'd1, 2'd0, 2'd3}, '{2'd3, 2'd1, 2'd0, 2'd2},
        '{2'd2, 2'd3, 2'd0, 2'd1}, '{2'd3, 2'd2, 2'd0, 2'd1},
        '{2'd1, 2'd2, 2'd3, 2'd0}, '{2'd1, 2'd3, 2'd2, 2'd0},
        '{2'd2, 2'd1, 2'd3, 2'd0}, '{2'd3, 2'd1, 2'd2, 2'd0},
        '{2'd2, 2'd3, 2'd1, 2'd0}, '{2'd3, 2'd2, 2'd1, 2'd0}
    };

    // One generator step, modulo 2^32
    function automatic logic [31:0] lcg_step(input logic [31:0] s);
        logic [31:0] prod;
        prod = s * LCG_MUL;
        return prod + LCG_ADD;
    endfunction

endpackage

[hw/rtl/lxrd_unshuffle.sv]
// Destination index of a data-block word, undoing the four-block shuffle.
module lxrd_unshuffle (
    input  lxrd_pkg::shuf_t shuf_type,
    input  lxrd_pkg::blk_t  blk,
    input  lxrd_pkg::off_t  off,
    output logic [7:0]      dest
);
    import lxrd_pkg::*;

    blk_t       dst_blk;
    logic [7:0] blk_base;
    logic [4:0] t_idx;

    // Shuffle type is always below 24 once reduced; guard the table index anyway
    assign t_idx = (shuf_type < SHUF_MOD) ? shuf_type : 5'd0;

    // Find the output block that holds this input block
    always_comb
    begin
        dst_blk = 2'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (ORDER[t_idx][i[1:0]] == blk)
            begin
                dst_blk = blk_t'(i);
            end
        end
    end

    assign blk_base = 8'(dst_blk) * BLK_WORDS;
    assign dest     = HDR_WORDS + blk_base + 8'(off);

endmodule

[hw/rtl/lcg_xor_record_decrypt.sv]
// Top level of the LCG keystream record decryptor.
//
// Takes one 16-bit record word per cycle and gives one result word per
// cycle while results are taken. A word accepted goes into the input
// register and then into the result register, which presents its result;
// a stalled result holds the input register and blocks further words until
// it is taken. The clock period is set by the generator step, one 32-bit
// constant multiply-add done combinationally between the input and result
// registers. Words 0/1 build the seed, word 3 holds the stored checksum,
// words 4..115 are decrypted and given their unshuffled position, word
// 115 reports the checksum, and words 116..129 are decrypted with a
// freshly reseeded generator. A last flag anywhere but word 115 or 129
// flags a bad length.
// No clearing pass is needed after reset.
module lcg_xor_record_decrypt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] word_in,
    input  logic        last,
    input  logic        word_valid,
    output logic        word_ready,
    output logic [15:0] word_out,
    output logic [7:0]  dest_index,
    output logic [1:0]  status,
    output logic        result_valid,
    input  logic        result_ready
);
    import lxrd_pkg::*;

    // Input stage
    logic        in_valid_reg;
    logic [15:0] in_word_reg;
    logic        in_last_reg;
    logic        advance;

    // Record state
    logic [7:0]  pos_reg,    pos_next;
    logic [31:0] seed_reg,   seed_next;
    logic [31:0] lcg_reg,    lcg_next;
    logic [15:0] stored_reg, stored_next;
    logic [15:0] sum_reg,    sum_next;
    shuf_t       shuf_reg,   shuf_next;
    blk_t        blk_reg,    blk_next;
    off_t        off_reg,    off_next;

    // Result stage
    logic        out_valid_reg;
    logic [15:0] out_word_reg, out_word_next;
    logic [7:0]  out_dest_reg, out_dest_next;
    status_t     out_stat_reg, out_stat_next;

    logic [31:0] lcg_adv;
    logic [7:0]  box_dest;
    logic [4:0]  shuf_raw;

    // Handshake: a word moves on when the result register is free or emptying
    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign word_ready = !in_valid_reg || advance;

    // Generator step, reseeded at the first optional word
    assign lcg_adv  = lcg_step((pos_reg == BOX_END) ? seed_reg : lcg_reg);
    // Seed bits 17..13 span the two seed words
    assign shuf_raw = {in_word_reg[1:0], seed_reg[15:13]};

    lxrd_unshuffle u_unshuffle (
        .shuf_type (shuf_reg),
        .blk       (blk_reg),
        .off       (off_reg),
        .dest      (box_dest)
    );

    // Per-word decode and state update
    always_comb
    begin
        pos_next      = pos_reg;
        seed_next     = seed_reg;
        lcg_next      = lcg_reg;
        stored_next   = stored_reg;
        sum_next      = sum_reg;
        shuf_next     = shuf_reg;
        blk_next      = blk_reg;
        off_next      = off_reg;
        out_word_next = in_word_reg;
        out_dest_next = 8'd0;
        out_stat_next = ST_PLAIN;

        if (pos_reg < HDR_WORDS)
        begin
            out_dest_next = pos_reg;
            if (pos_reg == SEED_LO)
            begin
                seed_next = {seed_reg[31:16], in_word_reg};
            end
            else if (pos_reg == SEED_HI)
            begin
                seed_next = {in_word_reg, seed_reg[15:0]};
                lcg_next  = {in_word_reg, seed_reg[15:0]};
                shuf_next = (shuf_raw >= SHUF_MOD) ? (shuf_raw - SHUF_MOD) : shuf_raw;
            end
            else if (pos_reg == SUM_WORD)
            begin
                stored_next = in_word_reg;
            end
        end
        else if (pos_reg < BOX_END)
        begin
            out_word_next = in_word_reg ^ lcg_adv[31:16];
            lcg_next      = lcg_adv;
            sum_next      = sum_reg + out_word_next;
            out_dest_next = box_dest;
            // Block / offset counters track the position within the data blocks
            if (off_reg == OFF_LAST)
            begin
                off_next = 5'd0;
                blk_next = blk_reg + 2'd1;
            end
            else
            begin
                off_next = off_reg + 5'd1;
            end
            if (pos_reg == BOX_LAST)
            begin
                out_stat_next = (sum_next == stored_reg) ? ST_PASS : ST_FAIL;
            end
        end
        else if (pos_reg < PARTY_END)
        begin
            out_word_next = in_word_reg ^ lcg_adv[31:16];
            lcg_next      = lcg_adv;
            out_dest_next = pos_reg;
        end

        // End of record, or step on (saturating past the last word)
        if (in_last_reg)
        begin
            if (pos_reg != BOX_LAST && pos_reg != PARTY_LAST)
            begin
                out_stat_next = ST_LENGTH;
            end
            pos_next = 8'd0;
            sum_next = 16'd0;
            blk_next = 2'd0;
            off_next = 5'd0;
        end
        else if (pos_reg < PARTY_END)
        begin
            pos_next = pos_reg + 8'd1;
        end
    end

    // Control and record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            seed_reg      <= '0;
            lcg_reg       <= '0;
            stored_reg    <= '0;
            sum_reg       <= '0;
            shuf_reg      <= '0;
            blk_reg       <= '0;
            off_reg       <= '0;
        end
        else
        begin
            if (word_ready)
            begin
                in_valid_reg <= word_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= pos_next;
                seed_reg      <= seed_next;
                lcg_reg       <= lcg_next;
                stored_reg    <= stored_next;
                sum_reg       <= sum_next;
                shuf_reg      <= shuf_next;
                blk_reg       <= blk_next;
                off_reg       <= off_next;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (word_ready && word_valid)
        begin
            in_word_reg <= word_in;
            in_last_reg <= last;
        end
        if (advance)
        begin
            out_word_reg <= out_word_next;
            out_dest_reg <= out_dest_next;
            out_stat_reg <= out_stat_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign word_out     = out_word_reg;
    assign dest_index   = out_dest_reg;
    assign status       = out_stat_reg;

`ifndef NO_ASSERTIONS
    // Position saturates one past the last optional word
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PARTY_END)
        else $error("position beyond record end");

    // Block counters agree with the position inside the data blocks
    a_blk_track: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg >= HDR_WORDS && pos_reg <= BOX_LAST) |->
        (pos_reg == HDR_WORDS + 8'(blk_reg) * BLK_WORDS + 8'(off_reg)))
        else $error("block counters out of step with position");

    // A last word restarts the record
    a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (pos_reg == 8'd0 && sum_reg == 16'd0))
        else $error("record state not cleared after last word");

    // Checksum status only on a data-block word
    a_sum_dest: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == ST_PASS || status == ST_FAIL)) |->
        (dest_index >= HDR_WORDS && dest_index <= BOX_LAST))
        else $error("checksum status on a word outside the data blocks");

    // A result appears only after a word has moved through
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(advance))
        else $error("result without a processed word");
`endif

endmodule

[dv/lcg_xor_record_decrypt_tb.sv]
// Self-checking testbench for the LCG keystream record decryptor.
`timescale 1ns / 1ps

module lcg_xor_record_decrypt_tb;

    import lxrd_pkg::*;

    localparam int unsigned RUN_ITEMS    = 950;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned MAX_REC      = 160;

    // Block order per shuffle type: output block i comes from input block [t][i]
    localparam int unsigned BLOCK_ORDER [24][4] = '{
        '{0, 1, 2, 3}, '{0, 1, 3, 2}, '{0, 2, 1, 3}, '{0, 3, 1, 2},
        '{0, 2, 3, 1}, '{0, 3, 2, 1}, '{1, 0, 2, 3}, '{1, 0, 3, 2},
        '{2, 0, 1, 3}, '{3, 0, 1, 2}, '{2, 0, 3, 1}, '{3, 0, 2, 1},
        '{1, 2, 0, 3}, '{1, 3, 0, 2}, '{2, 1, 0, 3}, '{3, 1, 0, 2},
        '{2, 3, 0, 1}, '{3, 2, 0, 1}, '{1, 2, 3, 0}, '{1, 3, 2, 0},
        '{2, 1, 3, 0}, '{3, 1, 2, 0}, '{2, 3, 1, 0}, '{3, 2, 1, 0}
    };

    typedef struct {
        logic [15:0] word;
        logic        fin;
        bit          drain;
    } cipher_word_t;

    typedef struct {
        logic [15:0] plain;
        logic [7:0]  dest;
        status_t     code;
    } plain_word_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic [15:0] word_in      = 16'd0;
    logic        last         = 1'b0;
    logic        word_valid   = 1'b0;
    logic        word_ready;
    logic [15:0] word_out;
    logic [7:0]  dest_index;
    logic [1:0]  status;
    logic        result_valid;
    logic        result_ready = 1'b0;

    cipher_word_t cipher_q[$];
    plain_word_t  decrypted_q[$];

    int unsigned errors     = 0;
    int unsigned items      = 0;
    bit          word_taken = 1'b0;

    // Predictor state
    logic [7:0]  rec_pos   = 8'd0;
    logic [31:0] rec_seed  = 32'd0;
    logic [31:0] gen_state = 32'd0;
    logic [15:0] rec_sum   = 16'd0;
    logic [15:0] run_sum   = 16'd0;

    lcg_xor_record_decrypt dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_in      (word_in),
        .last         (last),
        .word_valid   (word_valid),
        .word_ready   (word_ready),
        .word_out     (word_out),
        .dest_index   (dest_index),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
    end

    // Generator step, modulo 2^32
    function automatic logic [31:0] gen_advance(input logic [31:0] s);
        return s * LCG_MUL + LCG_ADD;
    endfunction

    // Position that undoes the block shuffle
    function automatic logic [7:0] box_index(input logic [7:0] p);
        int unsigned kind;
        int unsigned rel;
        int unsigned blk;
        int unsigned slot;
        kind = int'(rec_seed[17:13]) % 24;
        rel  = int'(p) - int'(HDR_WORDS);
        blk  = rel / int'(BLK_WORDS);
        slot = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (BLOCK_ORDER[kind][i] == blk)
                slot = i;
        end
        return 8'(int'(HDR_WORDS) + slot * int'(BLK_WORDS) + rel % int'(BLK_WORDS));
    endfunction

    // Expected result of one accepted word; advances the predictor state
    function automatic plain_word_t decrypt_word(input logic [15:0] w, input logic fin);
        plain_word_t r;
        r.plain = w;
        r.dest  = 8'd0;
        r.code  = ST_PLAIN;
        if (rec_pos < HDR_WORDS)
        begin
            r.dest = rec_pos;
            if (rec_pos == SEED_LO)
                rec_seed[15:0] = w;
            else if (rec_pos == SEED_HI)
            begin
                rec_seed[31:16] = w;
                gen_state       = rec_seed;
            end
            else if (rec_pos == SUM_WORD)
                rec_sum = w;
        end
        else if (rec_pos < BOX_END)
        begin
            gen_state = gen_advance(gen_state);
            r.plain   = w ^ gen_state[31:16];
            run_sum   = run_sum + r.plain;
            r.dest    = box_index(rec_pos);
            if (rec_pos == BOX_LAST)
                r.code = (run_sum == rec_sum) ? ST_PASS : ST_FAIL;
        end
        else if (rec_pos < PARTY_END)
        begin
            if (rec_pos == BOX_END)
                gen_state = rec_seed;
            gen_state = gen_advance(gen_state);
            r.plain   = w ^ gen_state[31:16];
            r.dest    = rec_pos;
        end
        // end of record, good or bad
        if (fin)
        begin
            if (rec_pos != BOX_LAST && rec_pos != PARTY_LAST)
                r.code = ST_LENGTH;
            rec_pos = 8'd0;
            run_sum = 16'd0;
        end
        else if (rec_pos < PARTY_END)
            rec_pos = rec_pos + 8'd1;
        return r;
    endfunction

    // Idle length: mostly short, a few long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(3, 1);
        else if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Encrypt a record of len words; the checksum word is right or deliberately off
    task automatic queue_record(input logic [31:0] seed, input int unsigned len,
                                input bit sum_ok, input bit drain);
        logic [15:0] rec [MAX_REC];
        logic [31:0] ks;
        logic [15:0] plain;
        logic [15:0] total;
        cipher_word_t cw;
        ks    = seed;
        total = 16'd0;
        for (int p = 0; p < int'(len); p++)
        begin
            plain = 16'($urandom);
            if (p == int'(SEED_LO))
                rec[p] = seed[15:0];
            else if (p == int'(SEED_HI))
                rec[p] = seed[31:16];
            else if (p < int'(HDR_WORDS))
                rec[p] = plain;
            else if (p < int'(BOX_END))
            begin
                ks     = gen_advance(ks);
                total  = total + plain;
                rec[p] = plain ^ ks[31:16];
            end
            else if (p < int'(PARTY_END))
            begin
                if (p == int'(BOX_END))
                    ks = seed;
                ks     = gen_advance(ks);
                rec[p] = plain ^ ks[31:16];
            end
            else
                rec[p] = plain;
        end
        if (len > int'(SUM_WORD))
            rec[SUM_WORD] = sum_ok ? total : total ^ 16'($urandom_range(16'hFFFF, 1));
        for (int p = 0; p < int'(len); p++)
        begin
            cw.word  = rec[p];
            cw.fin   = (p == int'(len) - 1);
            cw.drain = drain && (p == 0);
            cipher_q.push_back(cw);
        end
        items += len;
    endtask

    // Stimulus
    initial
    begin
        cipher_word_t cw;
        int unsigned  r;
        int unsigned  len;
        logic [31:0]  seed;

        // directed: single words with last, then short records of two to five words
        cw.drain = 1'b0;
        cw.fin   = 1'b1;
        cw.word  = 16'hFFFF;
        cipher_q.push_back(cw);
        cw.word  = 16'h0000;
        cipher_q.push_back(cw);
        items += 2;
        queue_record(32'hFFFF_FFFF, 2, 1'b1, 1'b0);
        queue_record(32'h0000_0000, 3, 1'b1, 1'b0);
        queue_record(32'h8000_0001, 4, 1'b1, 1'b0);
        queue_record(32'h7FFF_FFFE, 5, 1'b1, 1'b0);

        // full records, both valid lengths, the first after a pause for the pipeline to empty
        queue_record(32'hFFFF_FFFF, int'(PARTY_END), 1'b1, 1'b1);
        queue_record(32'h0000_0000, int'(BOX_END), 1'b1, 1'b0);

        while (items < RUN_ITEMS)
        begin
            r = $urandom_range(99);
            if ($urandom_range(9) == 0)
                seed = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            else
                seed = $urandom;
            if (r < 35)
                queue_record(seed, int'(BOX_END), 1'b1, $urandom_range(9) == 0);
            else if (r < 60)
                queue_record(seed, int'(PARTY_END), 1'b1, $urandom_range(9) == 0);
            else if (r < 70)
                queue_record(seed, $urandom_range(1) ? int'(BOX_END) : int'(PARTY_END),
                             1'b0, 1'b0);
            else if (r < 82)
            begin
                // last flag in the wrong place
                do
                    len = $urandom_range(int'(PARTY_LAST), 1);
                while (len == int'(BOX_END));
                queue_record(seed, len, 1'b1, 1'b0);
            end
            else if (r < 90)
                queue_record(seed, $urandom_range(int'(PARTY_END) + 15, int'(PARTY_END) + 1),
                             1'b1, 1'b0);
            else
            begin
                // noise words with random last flags, closed by a last
                len = $urandom_range(6, 1);
                for (int i = 0; i < int'(len); i++)
                begin
                    cw.word  = 16'($urandom);
                    cw.fin   = (i == int'(len) - 1) ? 1'b1 : 1'($urandom_range(1));
                    cw.drain = 1'b0;
                    cipher_q.push_back(cw);
                end
                items += len;
            end
        end

        while (cipher_q.size() != 0 || word_valid)
            @(posedge clk);
        while (decrypted_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[lcg_xor_record_decrypt] OK");
        else
            $display("[lcg_xor_record_decrypt] ERROR");
        $finish;
    end

    // Sender: presents words from the queue with random gaps
    int unsigned tx_gap   = 0;
    int unsigned tx_quiet = 0;

    always @(negedge clk)
    begin
        logic         nxt_valid;
        logic [15:0]  nxt_word;
        logic         nxt_last;
        cipher_word_t cw;
        if (rst_n)
        begin
            nxt_valid = word_valid;
            nxt_word  = word_in;
            nxt_last  = last;
            if (word_taken)
            begin
                nxt_valid = 1'b0;
                if (tx_quiet > 0)
                begin
                    tx_quiet--;
                    tx_gap = 0;
                end
                else
                begin
                    tx_gap = idle_len();
                    if ($urandom_range(49) == 0)
                        tx_quiet = $urandom_range(100, 30);
                end
            end
            if (!nxt_valid)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (cipher_q.size() != 0 &&
                         (!cipher_q[0].drain || decrypted_q.size() == 0))
                begin
                    cw        = cipher_q.pop_front();
                    nxt_valid = 1'b1;
                    nxt_word  = cw.word;
                    nxt_last  = cw.fin;
                end
            end
            word_valid <= nxt_valid;
            word_in    <= nxt_word;
            last       <= nxt_last;
        end
    end

    // Receiver: random back-pressure
    int unsigned rx_stall = 0;
    int unsigned rx_quiet = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_stall > 0)
            begin
                rx_stall--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                if (rx_quiet > 0)
                    rx_quiet--;
                else
                begin
                    rx_stall = idle_len();
                    if ($urandom_range(49) == 0)
                        rx_quiet = $urandom_range(100, 30);
                end
            end
        end
    end

    // Monitor: predict on each accepted word, check each accepted result
    always @(posedge clk)
    begin
        plain_word_t exp_w;
        word_taken = 1'b0;
        if (rst_n)
        begin
            if (word_valid && word_ready)
            begin
                decrypted_q.push_back(decrypt_word(word_in, last));
                word_taken = 1'b1;
            end
            if (result_valid && result_ready)
            begin
                if (decrypted_q.size() == 0)
                begin
                    $error("unexpected result word: word_out %h dest_index %0d status %0d",
                           word_out, dest_index, status);
                    errors++;
                end
                else
                begin
                    exp_w = decrypted_q.pop_front();
                    if (word_out !== exp_w.plain)
                    begin
                        $error("word_out: expected %h, got %h", exp_w.plain, word_out);
                        errors++;
                    end
                    if (dest_index !== exp_w.dest)
                    begin
                        $error("dest_index: expected %0d, got %0d", exp_w.dest, dest_index);
                        errors++;
                    end
                    if (status !== exp_w.code)
                    begin
                        $error("status: expected %0d, got %0d", exp_w.code, status);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("[lcg_xor_record_decrypt] ERROR");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/lxrd_pkg.sv
hw/rtl/lxrd_unshuffle.sv
hw/rtl/lcg_xor_record_decrypt.sv
dv/lcg_xor_record_decrypt_tb.sv
